// ===== sv/sibn_pkg.sv =====
package sibn_pkg;

   localparam int MAX_BASE    = 16;
   localparam int VALUE_W     = 32;
   localparam int DIGIT_W     = $clog2(MAX_BASE);
   localparam int LEN_W       = 5;
   localparam int CHAR_W      = 8;
   localparam int CSR_W       = 64;
   localparam int CSR_INDEX_W = 2;
   localparam int COUNT_W     = $clog2(VALUE_W + 1);
   localparam int BIT_CNT_W   = $clog2(VALUE_W);
   localparam int STACK_W     = VALUE_W * DIGIT_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_LEN  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_DIGITS_LO = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_DIGITS_HI = CSR_INDEX_W'(2);

   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SIGN,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   // start a division pass; chain reuses the previous quotient as dividend
   typedef struct packed {
      logic start;
      logic chain;
   } div_ctrl_type;

   typedef struct packed {
      logic               done;
      logic               q_nonzero;
      logic [DIGIT_W-1:0] remainder;
   } div_status_type;

endpackage

// ===== sv/sibn_divider.sv =====
module sibn_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  sibn_pkg::div_ctrl_type           ctrl,
   input  logic [sibn_pkg::VALUE_W-1:0]     dividend,
   input  logic [sibn_pkg::LEN_W-1:0]       divisor,
   output sibn_pkg::div_status_type         status
);

   // restoring long division, one dividend bit per cycle; quotient bits
   // shift in at the bottom as dividend bits leave at the top
   logic [sibn_pkg::VALUE_W-1:0]   quo_ff, quo_in;
   logic [sibn_pkg::DIGIT_W-1:0]   rem_ff, rem_in;
   logic [sibn_pkg::BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic                           running_ff, running_in;
   logic                           done_ff, done_in;
   logic                           nz_ff, nz_in;

   logic [sibn_pkg::LEN_W-1:0] trial;
   logic [sibn_pkg::LEN_W-1:0] diff;
   logic                       ge;

   always_comb begin
      trial = {rem_ff, quo_ff[sibn_pkg::VALUE_W-1]};
      ge    = (trial >= divisor);
      diff  = trial - divisor;

      quo_in     = quo_ff;
      rem_in     = rem_ff;
      bit_cnt_in = bit_cnt_ff;
      running_in = running_ff;
      nz_in      = nz_ff;
      done_in    = 1'b0;

      if (ctrl.start) begin
         if (!ctrl.chain) begin
            quo_in = dividend;
         end
         rem_in     = '0;
         nz_in      = 1'b0;
         bit_cnt_in = '0;
         running_in = 1'b1;
      end else if (running_ff) begin
         rem_in     = ge ? diff[sibn_pkg::DIGIT_W-1:0] : trial[sibn_pkg::DIGIT_W-1:0];
         quo_in     = {quo_ff[sibn_pkg::VALUE_W-2:0], ge};
         nz_in      = nz_ff | ge;
         bit_cnt_in = bit_cnt_ff + 1'b1;
         if (bit_cnt_ff == sibn_pkg::BIT_CNT_W'(sibn_pkg::VALUE_W - 1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         bit_cnt_ff <= '0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         bit_cnt_ff <= bit_cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      nz_ff  <= nz_in;
   end

   assign status.done      = done_ff;
   assign status.q_nonzero = nz_ff;
   assign status.remainder = rem_ff;

endmodule

// ===== sv/signed_integer_to_base_n_digits.sv =====
// channel   direction  ports                                       handshake
// request   in         req_value                                   start & !busy
// response  out        rsp_character, rsp_last                     rsp_strobe, one cycle
// config    in         csr_index, csr_write_data                   csr_write_enable
//
// one request keeps busy high through the alphabet check of each used character,
// the minus sign if the value is negative, and per digit a pass of the bit-serial
// divider plus the output of that digit; the worst case is radix 2 with a minus
// sign and 32 digits.
// reset is synchronous and clears control state; the alphabet resets to zero.
// the receiver cannot stall: each character is shown for exactly one cycle.
module signed_integer_to_base_n_digits (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [sibn_pkg::VALUE_W-1:0]  req_value,
   output logic                                 rsp_strobe,
   output logic [sibn_pkg::CHAR_W-1:0]          rsp_character,
   output logic                                 rsp_last,
   input  logic                                 csr_write_enable,
   input  logic [sibn_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [sibn_pkg::CSR_W-1:0]           csr_write_data
);

   // configuration registers
   logic [sibn_pkg::LEN_W-1:0] base_len_ff;
   logic [sibn_pkg::CSR_W-1:0] digits_lo_ff;
   logic [sibn_pkg::CSR_W-1:0] digits_hi_ff;

   // control and datapath registers
   sibn_pkg::state_type            state_ff, state_in;
   logic                           neg_ff, neg_in;
   logic [sibn_pkg::VALUE_W-1:0]   mag_ff, mag_in;
   logic [sibn_pkg::DIGIT_W-1:0]   idx_ff, idx_in;
   logic [sibn_pkg::COUNT_W-1:0]   nd_ff, nd_in;
   logic [sibn_pkg::STACK_W-1:0]   stack_ff, stack_in;

   logic [sibn_pkg::CHAR_W-1:0] alpha [sibn_pkg::MAX_BASE];
   logic [sibn_pkg::CHAR_W-1:0] cur_char;
   logic [sibn_pkg::VALUE_W-1:0] raw;
   logic                         accept;
   logic                         len_ok;
   logic                         dup;
   logic                         check_bad;
   logic                         check_end;
   logic                         more_digits;

   sibn_pkg::div_ctrl_type   div_ctrl;
   sibn_pkg::div_status_type div_status;

   // alphabet: characters 0..7 in the low word, 8..15 in the high word
   always_comb begin
      for (int k = 0; k < sibn_pkg::MAX_BASE; k++) begin
         if (k < 8) begin
            alpha[k] = digits_lo_ff[8*k +: 8];
         end else begin
            alpha[k] = digits_hi_ff[8*(k-8) +: 8];
         end
      end
   end

   assign busy   = (state_ff != sibn_pkg::ST_IDLE);
   assign accept = start && !busy;
   assign raw    = req_value;
   assign len_ok = (base_len_ff >= sibn_pkg::LEN_W'(2))
                && (base_len_ff <= sibn_pkg::LEN_W'(sibn_pkg::MAX_BASE));

   // alphabet check, one used character per cycle against all later used ones and the sign characters
   always_comb begin
      cur_char = alpha[idx_ff];
      dup      = 1'b0;
      for (int j = 0; j < sibn_pkg::MAX_BASE; j++) begin
         if ((sibn_pkg::LEN_W'(j) > {1'b0, idx_ff}) && (sibn_pkg::LEN_W'(j) < base_len_ff)
             && (alpha[j] == cur_char)) begin
            dup = 1'b1;
         end
      end
      check_bad = dup || (cur_char == sibn_pkg::CHAR_PLUS) || (cur_char == sibn_pkg::CHAR_MINUS);
      check_end = ({1'b0, idx_ff} == (base_len_ff - sibn_pkg::LEN_W'(1)));
   end

   // another pass while the quotient is nonzero and the digit buffer has room
   assign more_digits = div_status.q_nonzero
                     && (nd_ff != sibn_pkg::COUNT_W'(sibn_pkg::VALUE_W - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sibn_pkg::ST_IDLE: begin
            if (accept && len_ok) begin
               state_in = sibn_pkg::ST_CHECK;
            end
         end
         sibn_pkg::ST_CHECK: begin
            if (check_bad) begin
               state_in = sibn_pkg::ST_IDLE;
            end else if (check_end) begin
               state_in = neg_ff ? sibn_pkg::ST_SIGN : sibn_pkg::ST_DIVIDE;
            end
         end
         sibn_pkg::ST_SIGN: begin
            state_in = sibn_pkg::ST_DIVIDE;
         end
         sibn_pkg::ST_DIVIDE: begin
            if (div_status.done && !more_digits) begin
               state_in = sibn_pkg::ST_EMIT;
            end
         end
         sibn_pkg::ST_EMIT: begin
            if (nd_ff == sibn_pkg::COUNT_W'(1)) begin
               state_in = sibn_pkg::ST_IDLE;
            end
         end
         default: state_in = sibn_pkg::ST_IDLE;
      endcase
   end

   // outputs and divider commands
   always_comb begin
      rsp_strobe     = 1'b0;
      rsp_character  = alpha[stack_ff[sibn_pkg::DIGIT_W-1:0]];
      rsp_last       = 1'b0;
      div_ctrl.start = 1'b0;
      div_ctrl.chain = 1'b0;
      unique case (state_ff)
         sibn_pkg::ST_IDLE: begin
         end
         sibn_pkg::ST_CHECK: begin
            // first pass starts as the check ends unless a sign goes first
            div_ctrl.start = !check_bad && check_end && !neg_ff;
         end
         sibn_pkg::ST_SIGN: begin
            rsp_strobe     = 1'b1;
            rsp_character  = sibn_pkg::CHAR_MINUS;
            div_ctrl.start = 1'b1;
         end
         sibn_pkg::ST_DIVIDE: begin
            div_ctrl.start = div_status.done && more_digits;
            div_ctrl.chain = 1'b1;
         end
         sibn_pkg::ST_EMIT: begin
            rsp_strobe = 1'b1;
            rsp_last   = (nd_ff == sibn_pkg::COUNT_W'(1));
         end
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      idx_in   = idx_ff;
      nd_in    = nd_ff;
      stack_in = stack_ff;
      if (accept) begin
         neg_in = raw[sibn_pkg::VALUE_W-1];
         // most negative value wraps to its exact magnitude in unsigned bits
         mag_in = raw[sibn_pkg::VALUE_W-1] ? (~raw + sibn_pkg::VALUE_W'(1)) : raw;
         idx_in = '0;
         nd_in  = '0;
      end
      if (state_ff == sibn_pkg::ST_CHECK) begin
         idx_in = idx_ff + 1'b1;
      end
      if ((state_ff == sibn_pkg::ST_DIVIDE) && div_status.done) begin
         // newest digit on top: it is the most significant so far
         stack_in = {stack_ff[sibn_pkg::STACK_W-sibn_pkg::DIGIT_W-1:0], div_status.remainder};
         nd_in    = nd_ff + 1'b1;
      end
      if (state_ff == sibn_pkg::ST_EMIT) begin
         stack_in = stack_ff >> sibn_pkg::DIGIT_W;
         nd_in    = nd_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sibn_pkg::ST_IDLE;
         base_len_ff  <= '0;
         digits_lo_ff <= '0;
         digits_hi_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               sibn_pkg::CSR_BASE_LEN:  base_len_ff  <= csr_write_data[sibn_pkg::LEN_W-1:0];
               sibn_pkg::CSR_DIGITS_LO: digits_lo_ff <= csr_write_data;
               sibn_pkg::CSR_DIGITS_HI: digits_hi_ff <= csr_write_data;
               default: begin
               end
            endcase
         end
      end
      neg_ff   <= neg_in;
      mag_ff   <= mag_in;
      idx_ff   <= idx_in;
      nd_ff    <= nd_in;
      stack_ff <= stack_in;
   end

   sibn_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (mag_ff),
      .divisor  (base_len_ff),
      .status   (div_status)
   );

endmodule

// ===== dv/tb_signed_integer_to_base_n_digits.sv =====
`timescale 1ns / 1ps

module tb_signed_integer_to_base_n_digits;

   // register index that maps to no register, writes there must be dropped
   localparam logic [sibn_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = sibn_pkg::CSR_INDEX_W'(3);

   // worst request is radix 2 with 33 characters
   localparam int SETTLE_CYCLES = 1200;
   localparam int RANDOM_ITEMS  = 80;

   // decimal and hex alphabets, character k in byte k
   localparam logic [sibn_pkg::CSR_W-1:0] DEC_LO = 64'h3736353433323130;
   localparam logic [sibn_pkg::CSR_W-1:0] DEC_HI = 64'h0000000000003938;
   localparam logic [sibn_pkg::CSR_W-1:0] HEX_HI = 64'h4645444342413938;

   typedef struct packed {
      logic [sibn_pkg::CHAR_W-1:0] character;
      logic                        last;
   } char_result_type;

   logic                                clock;
   logic                                reset;
   logic                                start;
   logic                                busy;
   logic signed [sibn_pkg::VALUE_W-1:0] req_value;
   logic                                rsp_strobe;
   logic [sibn_pkg::CHAR_W-1:0]         rsp_character;
   logic                                rsp_last;
   logic                                csr_write_enable;
   logic [sibn_pkg::CSR_INDEX_W-1:0]    csr_index;
   logic [sibn_pkg::CSR_W-1:0]          csr_write_data;

   // own copy of the registers, updated at the edge that writes them
   logic [sibn_pkg::LEN_W-1:0]          alpha_len;
   logic [sibn_pkg::CSR_W-1:0]          alpha_lo;
   logic [sibn_pkg::CSR_W-1:0]          alpha_hi;

   // characters still owed by the block, oldest first
   char_result_type                     expected_chars[$];
   char_result_type                     oldest_char;

   int                                  mismatch_count;
   int                                  requests_accepted;
   int                                  chars_checked;
   int                                  config_writes;
   int                                  sender_idle_pct;

   signed_integer_to_base_n_digits DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value        (req_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_character    (rsp_character),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------

   // radix in range, no sign characters and no repeats among used symbols
   function automatic bit alphabet_usable();
      logic [127:0] alphabet;
      logic [7:0]   sym;
      int           i;
      int           j;
      alphabet = {alpha_hi, alpha_lo};
      if (alpha_len < 2 || alpha_len > sibn_pkg::MAX_BASE) return 1'b0;
      for (i = 0; i < alpha_len; i++) begin
         sym = alphabet[8*i +: 8];
         if (sym == sibn_pkg::CHAR_PLUS || sym == sibn_pkg::CHAR_MINUS) return 1'b0;
         for (j = i + 1; j < alpha_len; j++) begin
            if (alphabet[8*j +: 8] == sym) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // queue the characters one request must produce
   function automatic void format_value(input logic [sibn_pkg::VALUE_W-1:0] raw);
      logic [127:0]    alphabet;
      logic [31:0]     mag;
      logic [31:0]     radix;
      logic [7:0]      digit_syms[$];
      char_result_type item;
      int              i;
      if (!alphabet_usable()) return;
      alphabet = {alpha_hi, alpha_lo};
      radix    = 32'(alpha_len);
      if (raw[sibn_pkg::VALUE_W-1]) begin
         // magnitude of the most negative value still fits in 32 unsigned bits
         mag            = 32'd0 - raw;
         item.character = sibn_pkg::CHAR_MINUS;
         item.last      = 1'b0;
         expected_chars.push_back(item);
      end else begin
         mag = raw;
      end
      do begin
         digit_syms.push_front(alphabet[8*(mag % radix) +: 8]);
         mag = mag / radix;
      end while (mag != 0);
      for (i = 0; i < digit_syms.size(); i++) begin
         item.character = digit_syms[i];
         item.last      = (i == digit_syms.size() - 1);
         expected_chars.push_back(item);
      end
   endfunction

   // ---------------------------------------------------------------------
   // response checking: the block cannot be held off, so every strobe counts
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected character, expected none, got char %h last %b",
                     $time, rsp_character, rsp_last);
            mismatch_count++;
         end else begin
            oldest_char = expected_chars.pop_front();
            chars_checked++;
            if (rsp_character !== oldest_char.character) begin
               $display("%0t: character mismatch, expected %h, got %h",
                        $time, oldest_char.character, rsp_character);
               mismatch_count++;
            end
            if (rsp_last !== oldest_char.last) begin
               $display("%0t: last flag mismatch, expected %b, got %b",
                        $time, oldest_char.last, rsp_last);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------

   // enable is left high so back-to-back writes need no second assignment
   task automatic write_csr(input logic [sibn_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [sibn_pkg::CSR_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      case (idx)
         sibn_pkg::CSR_BASE_LEN:  alpha_len = data[sibn_pkg::LEN_W-1:0];
         sibn_pkg::CSR_DIGITS_LO: alpha_lo  = data;
         sibn_pkg::CSR_DIGITS_HI: alpha_hi  = data;
         default: begin
            // unused index, nothing changes
         end
      endcase
      config_writes++;
   endtask

   task automatic load_config(input logic [sibn_pkg::CSR_W-1:0] len_word,
                              input logic [sibn_pkg::CSR_W-1:0] lo,
                              input logic [sibn_pkg::CSR_W-1:0] hi);
      write_csr(sibn_pkg::CSR_BASE_LEN, len_word);
      write_csr(sibn_pkg::CSR_DIGITS_LO, lo);
      write_csr(sibn_pkg::CSR_DIGITS_HI, hi);
      csr_write_enable <= 1'b0;
   endtask

   // random pause before a request; a long one now and then lands mid-request
   task automatic sender_gap();
      int gap;
      gap = 0;
      if (sender_idle_pct == 0) return;
      while ($urandom_range(99) < sender_idle_pct) gap++;
      if ($urandom_range(15) == 0) gap += $urandom_range(1, 400);
      if (gap > 0) begin
         start     <= 1'b0;
         req_value <= $urandom;
         repeat (gap) @(posedge clock);
      end
   endtask

   // start stays high after acceptance until a gap or a settle lowers it
   task automatic send_value(input logic [sibn_pkg::VALUE_W-1:0] v);
      sender_gap();
      start     <= 1'b1;
      req_value <= v;
      @(posedge clock);
      while (busy) @(posedge clock);
      format_value(v);
      requests_accepted++;
   endtask

   // idle point: all characters in and the block surely finished
   task automatic settle();
      start <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // sixteen distinct symbols, none of them a sign
   function automatic logic [127:0] random_alphabet();
      logic [255:0] used;
      logic [127:0] alphabet;
      logic [7:0]   sym;
      int           k;
      used                       = '0;
      used[sibn_pkg::CHAR_PLUS]  = 1'b1;
      used[sibn_pkg::CHAR_MINUS] = 1'b1;
      for (k = 0; k < sibn_pkg::MAX_BASE; k++) begin
         do sym = 8'($urandom_range(255)); while (used[sym]);
         used[sym]             = 1'b1;
         alphabet[8*k +: 8] = sym;
      end
      return alphabet;
   endfunction

   // mostly small magnitudes and extremes, the rest full range
   function automatic logic [sibn_pkg::VALUE_W-1:0] random_value();
      logic [sibn_pkg::VALUE_W-1:0] mag;
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0;
         3, 4, 5: begin
            mag = $urandom_range(0, 300);
            return $urandom_range(1) ? mag : 32'd0 - mag;
         end
         default: return $urandom;
      endcase
   endfunction

   // random setting; some are unusable (bad radix, sign symbol, repeat)
   task automatic random_config();
      logic [127:0]               alphabet;
      logic [sibn_pkg::CSR_W-1:0] len_word;
      int                         len;
      int                         pick;
      int                         pos;
      int                         src;
      alphabet = random_alphabet();
      len      = $urandom_range(2, 16);
      pick     = $urandom_range(99);
      if (pick < 12) begin
         len = 2;
      end else if (pick < 16) begin
         len = $urandom_range(0, 1);
      end else if (pick < 20) begin
         len = $urandom_range(17, 31);
      end else if (pick < 24) begin
         pos = $urandom_range(0, len - 1);
         alphabet[8*pos +: 8] = $urandom_range(1) ? sibn_pkg::CHAR_PLUS : sibn_pkg::CHAR_MINUS;
      end else if (pick < 28) begin
         pos = $urandom_range(1, len - 1);
         src = $urandom_range(0, pos - 1);
         alphabet[8*pos +: 8] = alphabet[8*src +: 8];
      end
      // upper bits of the radix word are junk the block must drop
      len_word        = {$urandom, $urandom};
      len_word[sibn_pkg::LEN_W-1:0] = sibn_pkg::LEN_W'(len);
      load_config(len_word, alphabet[63:0], alphabet[127:64]);
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // registers reset to zero, so radix 0 gives nothing
   task automatic test_unconfigured();
      send_value(32'd0);
      send_value(32'hFFFF_FFFF);
      settle();
   endtask

   // decimal, plus a write to the unused index that must not disturb it
   task automatic test_decimal();
      load_config(sibn_pkg::CSR_W'(10), DEC_LO, DEC_HI);
      write_csr(CSR_UNUSED, '1);
      csr_write_enable <= 1'b0;
      send_value(32'd0);
      send_value(32'd9);
      send_value(32'd10);
      send_value(32'hFFFF_FFFF);
      send_value(32'h7FFF_FFFF);
      send_value(32'h8000_0000);
      settle();
   endtask

   // radix 2, longest outputs; unused bytes hold sign characters on purpose
   task automatic test_binary_extremes();
      load_config(sibn_pkg::CSR_W'(2), 64'h2D2D_2D2D_2D2D_3130, 64'h2B2B_2B2B_2B2B_2B2B);
      send_value(32'h8000_0000);
      send_value(32'h7FFF_FFFF);
      send_value(32'hFFFF_FFFF);
      settle();
   endtask

   // full sixteen symbol alphabet, exercises the high register
   task automatic test_hex();
      load_config(sibn_pkg::CSR_W'(16), DEC_LO, HEX_HI);
      send_value(32'h8000_0000);
      send_value(32'hDEAD_BEEF);
      send_value(32'd15);
      send_value(32'd16);
      settle();
   endtask

   // zero byte is an ordinary symbol; high-bit symbols too
   task automatic test_zero_symbol();
      load_config(sibn_pkg::CSR_W'(3), 64'h0000_0000_0080_FF00, 64'h0);
      send_value(32'd0);
      send_value(32'hFFFF_FFFB);
      settle();
   endtask

   // each unusable alphabet must swallow the request silently
   task automatic test_unusable_alphabets();
      // radix one
      load_config(sibn_pkg::CSR_W'(1), DEC_LO, DEC_HI);
      send_value(32'd5);
      settle();
      // radix above the cap
      load_config(sibn_pkg::CSR_W'(17), DEC_LO, HEX_HI);
      send_value(32'd5);
      settle();
      // largest radix word, junk above the field
      load_config(64'hFFFF_FFFF_FFFF_FFFF, DEC_LO, HEX_HI);
      send_value(32'h8000_0000);
      settle();
      // plus sign among the used symbols
      load_config(sibn_pkg::CSR_W'(10), 64'h3736_3534_3332_2B30, DEC_HI);
      send_value(32'd7);
      settle();
      // minus sign in the last used slot
      load_config(sibn_pkg::CSR_W'(16), DEC_LO, 64'h2D45_4443_4241_3938);
      send_value(32'hFFFF_FFF0);
      settle();
      // first and last symbols equal
      load_config(sibn_pkg::CSR_W'(16), DEC_LO, 64'h3045_4443_4241_3938);
      send_value(32'd123);
      settle();
   endtask

   // random settings, three sender idling profiles
   task automatic test_random_alphabets();
      int  valid_items;
      int  batch;
      bit  usable;
      valid_items = 0;
      while (valid_items < RANDOM_ITEMS) begin
         if (valid_items < RANDOM_ITEMS / 3)
            sender_idle_pct = 19;
         else if (valid_items < 2 * RANDOM_ITEMS / 3)
            sender_idle_pct = 79;
         else
            sender_idle_pct = 0;
         random_config();
         usable = alphabet_usable();
         batch  = usable ? $urandom_range(4, 12) : $urandom_range(2, 4);
         repeat (batch) send_value(random_value());
         if (usable) valid_items += batch;
         settle();
      end
   endtask

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------
   initial begin
      reset             <= 1'b1;
      start             <= 1'b0;
      req_value         <= '0;
      csr_write_enable  <= 1'b0;
      csr_index         <= sibn_pkg::CSR_BASE_LEN;
      csr_write_data    <= '0;
      alpha_len         = '0;
      alpha_lo          = '0;
      alpha_hi          = '0;
      mismatch_count    = 0;
      requests_accepted = 0;
      chars_checked     = 0;
      config_writes     = 0;
      sender_idle_pct   = 19;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_unconfigured();
      test_decimal();
      test_binary_extremes();
      test_hex();
      test_zero_symbol();
      test_unusable_alphabets();
      test_random_alphabets();
      settle();

      $display("covered %0d requests and %0d characters over %0d register writes,",
               requests_accepted, chars_checked, config_writes);
      $display("radix 0 to 31, sign and repeated symbols, extremes of the signed range");
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // hang guard, several times the slowest correct run
   initial begin
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== files.f =====
sv/sibn_pkg.sv
sv/sibn_divider.sv
sv/signed_integer_to_base_n_digits.sv
dv/tb_signed_integer_to_base_n_digits.sv
